// ===== src/mrm_pkg.sv =====
// Shared types and constants for the MMIO region map.
// No dependencies; imported by every module of the block.
package mrm_pkg;

    localparam int REGION_SLOTS = 16;
    localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);
    localparam int ADDR_W = 64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_MISS    = 2'd3
    } t_status;

    typedef enum logic {
        ACT_REGISTER = 1'b0,
        ACT_LOOKUP   = 1'b1
    } t_action;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr;

endpackage

// ===== src/mrm_table.sv =====
// Region table storage: one write port, one registered read port.
// Depends on mrm_pkg.
module mrm_table
    import mrm_pkg::*;
(
    input  logic             i_clk,
    input  t_wr              i_wr,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [REGION_SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/mrm_cmp.sv =====
// Shared span comparator: overlap test for register beats, containment for lookups.
// Depends on mrm_pkg. Region ends are formed 65 bits wide.
module mrm_cmp
    import mrm_pkg::*;
(
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_span,
    input  t_entry            i_entry,
    output logic              o_hit
);

    logic [ADDR_W:0] old_end;
    logic [ADDR_W:0] new_end;
    logic            below_old;
    logic            old_below_new;
    logic            overlap;
    logic            contained;

    always_comb begin
        old_end       = {1'b0, i_entry.base} + {1'b0, i_entry.size};
        new_end       = {1'b0, i_address} + {1'b0, i_span};
        below_old     = {1'b0, i_address} < old_end;
        old_below_new = {1'b0, i_entry.base} < new_end;
        // zero-size spans on either side never overlap
        overlap   = (i_span != '0) && (i_entry.size != '0) && below_old && old_below_new;
        contained = (i_address >= i_entry.base) && below_old;
        o_hit     = (i_action == ACT_LOOKUP) ? contained : overlap;
    end

endmodule

// ===== src/mmio_region_map_top.sv =====
// MMIO region map: top level with the scan sequencer and result register.
// Depends on mrm_pkg, mrm_table and mrm_cmp.
//
// Input channel: i_valid / o_stall carry action, address and span. A register
// beat appends a region unless the table is full or the span overlaps a stored
// region; a lookup beat returns the first stored region containing the address.
// Output channel: o_valid / i_stall carry status, region_index, region_start.
//
// After the accepting edge the sequencer scans the stored regions in S_SCAN (the
// comparator looks at one table entry per cycle through the registered read port)
// and then loads the result from S_DONE. A register beat on a full table, or any
// beat on an empty one, answers without a scan.
// o_stall is high from the cycle after the accepting beat until the result is
// loaded, so one item is in flight at a time: a new beat is taken only after the
// previous result is loaded. The next item may be taken while the previous
// result still waits. If the receiver stalls, the result holds in the output
// register and the sequencer waits with the next result until the register frees.
// Reset (i_rst_n low, synchronous) empties the table and drops any result; table
// contents are not cleared, only entries below the count are ever compared.
module mmio_region_map_top
    import mrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [ADDR_W-1:0] i_span,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [3:0]        o_region_index,
    output logic [ADDR_W-1:0] o_region_start
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic              r_action;
    logic [ADDR_W-1:0] r_address;
    logic [ADDR_W-1:0] r_span;
    t_status           r_res_status;
    logic [3:0]        r_res_idx;
    logic [ADDR_W-1:0] r_res_start;
    logic              r_o_valid;
    logic [1:0]        r_o_status;
    logic [3:0]        r_o_idx;
    logic [ADDR_W-1:0] r_o_start;

    logic              accept;
    logic              load;
    logic              hit;
    logic              last;
    logic [CNT_W:0]    idx_next;
    logic [IDX_W+3:0]  idx_wide;
    logic [CNT_W+3:0]  cnt_wide;
    logic [IDX_W-1:0]  rd_addr;
    t_entry            rd_data;
    t_wr               wr;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign load     = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    assign idx_next = (CNT_W + 1)'(r_idx) + 1'b1;
    assign last     = (idx_next == {1'b0, r_count});
    assign idx_wide = {4'b0, r_idx};
    assign cnt_wide = {4'b0, r_count};
    // read one entry ahead so the comparator sees a new entry every cycle
    assign rd_addr  = (r_state == S_SCAN) ? idx_next[IDX_W-1:0] : '0;

    always_comb begin
        wr.en        = load && (r_action == ACT_REGISTER) && (r_res_status == ST_OK);
        wr.addr      = r_count[IDX_W-1:0];
        wr.data.base = r_address;
        wr.data.size = r_span;
    end

    mrm_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mrm_cmp u_cmp (
        .i_action  (r_action),
        .i_address (r_address),
        .i_span    (r_span),
        .i_entry   (rd_data),
        .o_hit     (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_action    <= i_action;
                        r_address   <= i_address;
                        r_span      <= i_span;
                        r_idx       <= '0;
                        r_res_start <= '0;
                        if (i_action == ACT_REGISTER) begin
                            if (r_count >= CNT_W'(REGION_SLOTS)) begin
                                r_res_status <= ST_FULL;
                                r_res_idx    <= '0;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= ST_OK;
                                r_res_idx    <= cnt_wide[3:0];
                                r_state      <= (r_count == '0) ? S_DONE : S_SCAN;
                            end
                        end else begin
                            r_res_status <= ST_MISS;
                            r_res_idx    <= '0;
                            r_state      <= (r_count == '0) ? S_DONE : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (r_action == ACT_LOOKUP) begin
                            r_res_status <= ST_OK;
                            r_res_idx    <= idx_wide[3:0];
                            r_res_start  <= rd_data.base;
                        end else begin
                            r_res_status <= ST_OVERLAP;
                            r_res_idx    <= '0;
                        end
                        r_state <= S_DONE;
                    end else if (last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= idx_next[IDX_W-1:0];
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_o_status <= r_res_status;
                        r_o_idx    <= r_res_idx;
                        r_o_start  <= r_res_start;
                        if (wr.en) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_region_index = r_o_idx;
    assign o_region_start = r_o_start;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(REGION_SLOTS))
        else $error("region count beyond capacity");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_count == CNT_W'(REGION_SLOTS)))
        else $error("table-full reported with free slots");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_MISS) |-> (o_region_index == '0 && o_region_start == '0))
        else $error("miss result carries index or base");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1))
        else $error("region count moved by more than one");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((CNT_W + 1)'(r_idx) < {1'b0, r_count}))
        else $error("scan index past stored regions");
`endif

endmodule
